// File: sv/tlb_pkg.sv
// Shared types and constants for the translation lookaside buffer.
// Used by tlb_ctrl, tlb_datapath and tlb_lookup_fifo_lru; depends on nothing.
package tlb_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_MODE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] ENTRIES_RESET = 5'd16;

    // Field codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;
    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    localparam int TAG_W = 16;

    // One stored translation
    typedef struct packed {
        logic [TAG_W-1:0] frame;
        logic [TAG_W-1:0] page;
        logic [TAG_W-1:0] pid;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RESP,
        ST_SHIFT,
        ST_APPEND
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the accepted request
        logic scan_start;   // rewind the read pointer for a search
        logic scan_step;    // read next entry, compare previous one
        logic evict_start;  // set up removal of the oldest entries
        logic lru_start;    // set up removal of the entry that hit
        logic shift_step;   // move one entry down over the gap
        logic shift_finish; // shrink the fill count by the gap size
        logic append;       // write the youngest entry
        logic load_out;     // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_insert;
        logic cap_zero;
        logic empty;
        logic need_evict;
        logic scan_hit;
        logic scan_miss;
        logic shift_done;
        logic out_free;
        logic hit;
        logic lru_mode;
    } sts_t;

endpackage

// File: sv/tlb_lookup_fifo_lru.sv
// Lookup over n held entries: searched oldest first, stopping at the first hit;
// an empty or disabled table misses unsearched; a result waits while the last one is unread.
// An LRU hit then shifts the younger entries down and re-appends the hit entry as youngest.
// Insert: appends; when full, the k oldest entries are evicted first. Dropped if disabled.
// One request at a time; one entry per cycle in search and shift. Uses tlb_ctrl, tlb_datapath.
// Sync active-low reset: fill count zero (no memory sweep), entries_in_use 16, FIFO mode.
module tlb_lookup_fifo_lru
    import tlb_pkg::*;
#(
    parameter int TLB_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // process_id, page_number, frame_number
    input  logic [0:0]            s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // found_frame
    output logic [0:0]            m_tuser    // hit
);

    cmd_t cmd;
    sts_t sts;

    tlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlb_datapath #(
        .TLB_DEPTH (TLB_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register loaded while occupied");

    // Memory and pointer operations never overlap
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.scan_step, cmd.shift_step, cmd.append, cmd.load_out}))
        else $error("overlapping datapath operations");

    // An accepted request blocks the input until it is processed
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted request");

    // A result is only loaded after a lookup request
    a_result_for_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !sts.req_insert)
        else $error("result produced for an insert request");

endmodule

// File: sv/tlb_ctrl.sv
// Sequencer for the translation lookaside buffer: decode, search, respond, shift, append.
// Depends on tlb_pkg; drives tlb_datapath through cmd_t and reads sts_t.
module tlb_ctrl
    import tlb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (sts.req_insert) begin
                    if (sts.cap_zero)        state_next = ST_IDLE;
                    else if (sts.need_evict) state_next = ST_SHIFT;
                    else                     state_next = ST_APPEND;
                end else begin
                    if (sts.cap_zero || sts.empty) state_next = ST_RESP;
                    else                           state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_hit || sts.scan_miss) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    if (sts.hit && sts.lru_mode == MODE_LRU) state_next = ST_SHIFT;
                    else                                     state_next = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (sts.shift_done) state_next = ST_APPEND;
            end
            ST_APPEND: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: begin
                cmd.scan_start  = !sts.req_insert && !sts.cap_zero && !sts.empty;
                cmd.evict_start = sts.req_insert && !sts.cap_zero && sts.need_evict;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_RESP: begin
                cmd.load_out  = sts.out_free;
                cmd.lru_start = sts.out_free && sts.hit && sts.lru_mode == MODE_LRU;
            end
            ST_SHIFT: begin
                cmd.shift_step   = 1'b1;
                cmd.shift_finish = sts.shift_done;
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/tlb_datapath.sv
// Datapath of the translation lookaside buffer: entry memory, fill count, pointers,
// configuration registers and the result register. Depends on tlb_pkg.
module tlb_datapath
    import tlb_pkg::*;
#(
    parameter int TLB_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [47:0]           s_tdata,
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic [0:0]            m_tuser,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int AW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int CW = $clog2(TLB_DEPTH + 1);
    localparam int XW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(TLB_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TLB_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    entry_t mem [TLB_DEPTH];

    logic [CFG_DATA_W-1:0] entries_reg;
    logic                  mode_reg;

    logic                  req_op_reg;
    entry_t                req_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] pend_pos_reg;
    logic          pend_reg;
    logic [CW-1:0] gap_reg;
    entry_t        rd_data_reg;

    logic          hit_reg;
    logic [15:0]   hit_frame_reg;
    logic [CW-1:0] hit_pos_reg;

    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [15:0]   out_frame_reg;

    logic [CW-1:0] cap;
    logic [CW-1:0] evict_gap;
    logic          rd_en;
    logic          match;
    logic          shift_wr;
    logic [CW-1:0] shift_dst;
    entry_t        app_entry;

    // Effective capacity saturates at the table depth
    always_comb begin
        if (XW'(entries_reg) > DEPTH_X) cap = DEPTH_C;
        else                            cap = CW'(entries_reg);
    end

    assign evict_gap = count_reg - cap + ONE_C;
    assign rd_en     = (cmd.scan_step || cmd.shift_step) && (ptr_reg < count_reg);
    assign match     = pend_reg && rd_data_reg.pid == req_reg.pid
                       && rd_data_reg.page == req_reg.page;
    assign shift_wr  = cmd.shift_step && pend_reg;
    assign shift_dst = pend_pos_reg - gap_reg;

    always_comb begin
        app_entry      = req_reg;
        app_entry.frame = (req_op_reg == OP_INSERT) ? req_reg.frame : hit_frame_reg;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= ENTRIES_RESET;
            mode_reg    <= MODE_FIFO;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENTRIES_IN_USE:   entries_reg <= cfg_wdata;
                REG_REPLACEMENT_MODE: mode_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Request capture and search result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_op_reg    <= s_tuser[0];
            req_reg.pid   <= s_tdata[15:0];
            req_reg.page  <= s_tdata[31:16];
            req_reg.frame <= s_tdata[47:32];
            hit_reg       <= 1'b0;
            hit_frame_reg <= '0;
        end else if (cmd.scan_step && match) begin
            hit_reg       <= 1'b1;
            hit_frame_reg <= rd_data_reg.frame;
            hit_pos_reg   <= pend_pos_reg;
        end
    end

    // Entry memory: one read and one write port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
        end
        if (shift_wr) begin
            mem[shift_dst[AW-1:0]] <= rd_data_reg;
        end else if (cmd.append) begin
            mem[count_reg[AW-1:0]] <= app_entry;
        end
    end

    // Pointers, gap size and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                ptr_reg  <= '0;
                pend_reg <= 1'b0;
            end else if (cmd.evict_start) begin
                ptr_reg  <= evict_gap;
                gap_reg  <= evict_gap;
                pend_reg <= 1'b0;
            end else if (cmd.lru_start) begin
                ptr_reg  <= hit_pos_reg + ONE_C;
                gap_reg  <= ONE_C;
                pend_reg <= 1'b0;
            end else if (cmd.scan_step || cmd.shift_step) begin
                pend_reg <= rd_en;
                if (rd_en) begin
                    ptr_reg      <= ptr_reg + ONE_C;
                    pend_pos_reg <= ptr_reg;
                end
            end
            if (cmd.shift_finish) begin
                count_reg <= count_reg - gap_reg;
            end else if (cmd.append) begin
                count_reg <= count_reg + ONE_C;
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_hit_reg   <= hit_reg;
            out_frame_reg <= hit_frame_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_frame_reg;
    assign m_tuser[0] = out_hit_reg;

    // Status
    always_comb begin
        sts            = '0;
        sts.req_insert = (req_op_reg == OP_INSERT);
        sts.cap_zero   = (cap == '0);
        sts.empty      = (count_reg == '0);
        sts.need_evict = (count_reg >= cap);
        sts.scan_hit   = match;
        sts.scan_miss  = (ptr_reg >= count_reg) && !match;
        sts.shift_done = (ptr_reg >= count_reg) && !pend_reg;
        sts.out_free   = !out_valid_reg || m_tready;
        sts.hit        = hit_reg;
        sts.lru_mode   = mode_reg;
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench for tlb_lookup_fifo_lru: a directed table, then random
// phases over capacity and replacement settings, checked against an internal TLB model.
// Depends on tlb_pkg and the tlb_lookup_fifo_lru RTL.
module tb
    import tlb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TLB_DEPTH     = 16;
    localparam int SETTLE_CYCLES = 40;     // longest insert eviction or LRU shift, with margin
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 66;
    localparam int POOL_SIZE     = 8;
    localparam int PRESSURE_AT   = 170;    // result count at which the receiver holds off
    localparam int PRESSURE_LEN  = 400;

    typedef struct packed {
        logic        hit;
        logic [15:0] frame;
    } lookup_result_t;

    typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   op;
        logic [15:0]            pid;
        logic [15:0]            page;
        logic [15:0]            frame;
        logic                   typed;      // expected result given in the row
        logic                   exp_hit;
        logic [15:0]            exp_frame;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_value;
    } directed_row_t;

    localparam int N_DIRECTED = 27;

    // Directed stimulus: extremes, duplicates, disabled table, LRU moves, shrink, saturation
    directed_row_t directed_rows [N_DIRECTED] = '{
        // empty after reset: misses, then inserts of the extreme tags, which hit
        '{ROW_REQUEST,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_INSERT, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'hFFFF,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        // duplicate tag: oldest match wins
        '{ROW_REQUEST,  OP_INSERT, 16'h0000, 16'h0000, 16'h1234, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        // one tag matches, the other not
        '{ROW_REQUEST,  OP_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        // disabled table: lookups miss, inserts dropped
        '{ROW_REGISTER, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_INSERT, 16'h5555, 16'hAAAA, 16'h0F0F, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        // re-enabled: held entries visible again
        '{ROW_REGISTER, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd16},
        '{ROW_REQUEST,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'h5555, 16'hAAAA, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        // LRU: hit moves to youngest, the duplicate becomes the oldest match
        '{ROW_REGISTER, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_REPLACEMENT_MODE, 5'(MODE_LRU)},
        '{ROW_REQUEST,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        // capacity below fill: search all, next insert trims then appends
        '{ROW_REGISTER, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd2},
        '{ROW_REQUEST,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_INSERT, 16'hAAAA, 16'h5555, 16'hF0F0, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        // capacity above depth saturates
        '{ROW_REGISTER, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd31},
        '{ROW_REQUEST,  OP_INSERT, 16'h1111, 16'h2222, 16'h3333, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REQUEST,  OP_LOOKUP, 16'h1111, 16'h2222, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_ENTRIES_IN_USE, 5'd0},
        '{ROW_REGISTER, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000,
          REG_REPLACEMENT_MODE, 5'(MODE_FIFO)}
    };

    // Capacity per random phase: extremes, saturation and shrink steps
    int unsigned phase_entries [12] = '{16, 1, 31, 0, 2, 8, 16, 3, 17, 4, 15, 12};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;   // process_id, page_number, frame_number
    logic [0:0]            s_tuser;   // operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // found_frame
    logic [0:0]            m_tuser;   // hit

    tlb_lookup_fifo_lru #(.TLB_DEPTH(TLB_DEPTH)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // TLB model state, in age order with the oldest at 0
    entry_t                tlb_table [TLB_DEPTH];
    int unsigned           tlb_fill     = 0;
    logic [CFG_DATA_W-1:0] tlb_entries  = ENTRIES_RESET;
    logic                  tlb_mode     = MODE_FIFO;

    lookup_result_t        pending_lookups [$];
    int                    mismatch_count = 0;

    logic [31:0]           key_pool [POOL_SIZE];
    int                    pool_count  = 0;
    int                    pool_next   = 0;
    bit                    sender_burst = 0;

    function automatic int unsigned tlb_capacity();
        return (tlb_entries > TLB_DEPTH) ? TLB_DEPTH : tlb_entries;
    endfunction

    // Drop the entry at pos and close the gap
    function automatic void tlb_remove(int unsigned pos);
        if (pos >= tlb_fill) return;
        for (int unsigned i = pos; i + 1 < tlb_fill; i++) begin
            tlb_table[i] = tlb_table[i + 1];
        end
        tlb_fill--;
    endfunction

    function automatic void tlb_append(entry_t e);
        if (tlb_fill >= TLB_DEPTH) return;
        tlb_table[tlb_fill] = e;
        tlb_fill++;
    endfunction

    // Advance the model by one request; returns 1 when a lookup result is due
    function automatic bit predict_tlb(input logic op, input entry_t req,
                                       output lookup_result_t res);
        int unsigned cap;
        int unsigned hit_pos;
        bit          found;
        entry_t      hit_entry;
        cap   = tlb_capacity();
        res   = '0;
        found = 0;
        hit_pos = 0;
        if (op == OP_INSERT) begin
            if (cap != 0) begin
                while (tlb_fill >= cap) tlb_remove(0);
                tlb_append(req);
            end
            return 0;
        end
        if (cap == 0) return 1;
        for (int unsigned i = 0; i < tlb_fill; i++) begin
            if (!found && tlb_table[i].pid == req.pid && tlb_table[i].page == req.page) begin
                found   = 1;
                hit_pos = i;
            end
        end
        if (found) begin
            hit_entry = tlb_table[hit_pos];
            res.hit   = 1'b1;
            res.frame = hit_entry.frame;
            if (tlb_mode == MODE_LRU) begin
                tlb_remove(hit_pos);
                tlb_append(hit_entry);
            end
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one request, hold it until accepted, then record what it should return
    task automatic send_request(input logic op, input entry_t req, input bit typed,
                                input lookup_result_t typed_res);
        int             gap;
        lookup_result_t res;
        if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.frame, req.page, req.pid};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (predict_tlb(op, req, res)) begin
            pending_lookups.push_back(typed ? typed_res : res);
        end
    endtask

    // Hold the input idle until every result is back and the block has finished
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_ENTRIES_IN_USE) tlb_entries = value;
        else tlb_mode = value[0];
    endtask

    // Mostly tags already inserted, some near misses, some colliding small tags
    task automatic random_request(output bit counted);
        logic   op;
        entry_t req;
        int     pick;
        logic [31:0] key;
        req.pid   = 16'($urandom);
        req.page  = 16'($urandom);
        req.frame = 16'($urandom);
        op   = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_LOOKUP;
        pick = $urandom_range(0, 99);
        key  = (pool_count != 0) ? key_pool[$urandom_range(0, pool_count - 1)] : '0;
        if (pool_count != 0 && pick < 55) begin
            {req.pid, req.page} = key;
        end else if (pool_count != 0 && pick < 63) begin
            req.pid = key[31:16];
        end else if (pool_count != 0 && pick < 70) begin
            req.page = key[15:0];
        end else if (pick < 80) begin
            req.pid  = 16'($urandom_range(0, 3));
            req.page = 16'($urandom_range(0, 3));
        end
        if (op == OP_INSERT) begin
            key_pool[pool_next] = {req.pid, req.page};
            pool_next = (pool_next + 1) % POOL_SIZE;
            if (pool_count < POOL_SIZE) pool_count++;
        end
        counted = !(op == OP_INSERT && tlb_capacity() == 0);
        send_request(op, req, 1'b0, '0);
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold-off, compare with the oldest expectation
    initial begin
        int             stall;
        int             results_seen;
        bit             recv_burst;
        bit             pressure_done;
        lookup_result_t got;
        lookup_result_t want;
        results_seen  = 0;
        recv_burst    = 0;
        pressure_done = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            if (!pressure_done && results_seen == PRESSURE_AT) begin
                stall = PRESSURE_LEN;
                pressure_done = 1;
            end else begin
                stall = recv_burst ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            results_seen++;
            got.hit   = m_tuser[0];
            got.frame = m_tdata;
            if (pending_lookups.size() == 0) begin
                report_mismatch($sformatf("result hit=%0b frame=%h with nothing pending",
                                          got.hit, got.frame));
            end else begin
                want = pending_lookups.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("lookup %0d: hit %b, expected %b",
                                              results_seen, got.hit, want.hit));
                if (got.frame !== want.frame)
                    report_mismatch($sformatf("lookup %0d: frame %h, expected %h",
                                              results_seen, got.frame, want.frame));
            end
        end
    end

    // Request side: reset, directed table, random phases, drain
    initial begin
        entry_t         req;
        lookup_result_t typed_res;
        bit             counted;
        int             done_items;
        int             guard;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_REGISTER) begin
                settle_block();
                write_register(directed_rows[r].reg_idx, directed_rows[r].reg_value);
            end else begin
                req.pid         = directed_rows[r].pid;
                req.page        = directed_rows[r].page;
                req.frame       = directed_rows[r].frame;
                typed_res.hit   = directed_rows[r].exp_hit;
                typed_res.frame = directed_rows[r].exp_frame;
                send_request(directed_rows[r].op, req, directed_rows[r].typed, typed_res);
            end
        end

        // Random phases, each under its own capacity and mode
        for (int p = 0; p < 12; p++) begin
            settle_block();
            write_register(REG_ENTRIES_IN_USE, CFG_DATA_W'(phase_entries[p]));
            write_register(REG_REPLACEMENT_MODE,
                           CFG_DATA_W'((p < 2) ? p : $urandom_range(0, 1)));
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                random_request(counted);
                if (counted) done_items++;
            end
        end

        // Drain
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_lookups.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_lookups.size() != 0)
            report_mismatch($sformatf("%0d lookup results never arrived",
                                      pending_lookups.size()));
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
